FILE: rtl/mscs_pkg.sv
// Package: word types, quote mode encoding and structural character codes for the scanner.
package mscs_pkg;

    localparam int unsigned TEXT_W   = 64;
    localparam int unsigned COUNT_W  = 4;
    localparam int unsigned OFFSET_W = 32;
    localparam int unsigned CHAR_W   = 8;

    localparam logic [CHAR_W-1:0] CH_LT     = 8'h3C;  // <
    localparam logic [CHAR_W-1:0] CH_GT     = 8'h3E;  // >
    localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;  // /
    localparam logic [CHAR_W-1:0] CH_EQUALS = 8'h3D;  // =
    localparam logic [CHAR_W-1:0] CH_AMP    = 8'h26;  // &
    localparam logic [CHAR_W-1:0] CH_DQUOTE = 8'h22;  // "
    localparam logic [CHAR_W-1:0] CH_SQUOTE = 8'h27;  // '

    typedef enum logic [1:0] {
        QM_NONE   = 2'd0,
        QM_DOUBLE = 2'd1,
        QM_SINGLE = 2'd2
    } quote_mode_t;

    typedef struct packed {
        logic [TEXT_W-1:0]  text_word;
        logic [COUNT_W-1:0] byte_count;
        logic               stream_start;
    } scan_in_t;

    typedef struct packed {
        logic [OFFSET_W-1:0] char_offset;
        logic [CHAR_W-1:0]   char_value;
        logic                last_of_word;
    } scan_out_t;

    function automatic logic is_plain_structural(input logic [CHAR_W-1:0] c);
        return (c == CH_LT) || (c == CH_GT) || (c == CH_SLASH) ||
               (c == CH_EQUALS) || (c == CH_AMP);
    endfunction

endpackage

FILE: rtl/mscs_lane_scan.sv
// Lane classifier: structural hit mask and quote mode chained across one word.
module mscs_lane_scan
    import mscs_pkg::*;
#(
    parameter int unsigned LANES = 8
) (
    input  logic [LANES*CHAR_W-1:0] lane_bytes,
    input  logic [LANES-1:0]        lane_en,
    input  quote_mode_t             quote_in,
    output logic [LANES-1:0]        hit_mask,
    output quote_mode_t             quote_out
);

    // Walk the lanes in byte order; each lane sees the mode its predecessor leaves.
    always_comb begin
        quote_mode_t q;
        logic [CHAR_W-1:0] c;
        q        = quote_in;
        hit_mask = '0;
        for (int k = 0; k < LANES; k++) begin
            c = lane_bytes[k*CHAR_W +: CHAR_W];
            if (lane_en[k]) begin
                case (q)
                    QM_DOUBLE: begin
                        if (c == CH_DQUOTE) begin
                            hit_mask[k] = 1'b1;
                            q           = QM_NONE;
                        end
                    end
                    QM_SINGLE: begin
                        if (c == CH_SQUOTE) begin
                            hit_mask[k] = 1'b1;
                            q           = QM_NONE;
                        end
                    end
                    default: begin
                        if (is_plain_structural(c)) begin
                            hit_mask[k] = 1'b1;
                        end else if (c == CH_DQUOTE) begin
                            hit_mask[k] = 1'b1;
                            q           = QM_DOUBLE;
                        end else if (c == CH_SQUOTE) begin
                            hit_mask[k] = 1'b1;
                            q           = QM_SINGLE;
                        end
                    end
                endcase
            end
        end
        quote_out = q;
    end

endmodule

FILE: rtl/markup_structural_char_scanner.sv
// Top level: markup structural character scanner, input register, scan and result drain stage.
//
// The scanner takes text as words of up to LANES bytes (earliest byte in the lowest bits) and
// gives one result word per structural character, in byte order: its offset from the start of
// the stream (wrapping at 32 bits) and its value, with last_of_word set on the final result of
// each input word. Outside quotes the structural characters are < > / = & and both quote marks;
// a quote mark opens a quote of its kind, inside which only the matching closing quote counts.
// An input word is taken every cycle as long as the drain stage can take its hits: a word with no
// structural character never waits for the drain stage, and a word with N structural characters
// occupies the drain stage until all N results have gone out, one result per cycle while m_ready
// is high, while the next word already waits in the input register. Results leave from the drain
// stage register, which is loaded from the input register. Setting stream_start clears the offset
// and the quote mode before that word is scanned.
module markup_structural_char_scanner
    import mscs_pkg::*;
#(
    parameter int unsigned LANES = 8
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  scan_in_t  s_word,
    output logic      m_valid,
    input  logic      m_ready,
    output scan_out_t m_word
);

    localparam int unsigned IDX_W = (LANES > 1) ? $clog2(LANES) : 1;
    localparam logic [COUNT_W-1:0] LANES_CNT = COUNT_W'(LANES);

    // Input register
    logic                    a_valid_reg;
    logic [LANES*CHAR_W-1:0] a_bytes_reg;
    logic [COUNT_W-1:0]      a_count_reg;
    logic                    a_start_reg;

    // Stream state
    logic [OFFSET_W-1:0] offset_reg;
    quote_mode_t         quote_reg;

    // Drain stage: pending hits of one word
    logic                    b_valid_reg;
    logic [LANES-1:0]        b_mask_reg;
    logic [LANES*CHAR_W-1:0] b_bytes_reg;
    logic [OFFSET_W-1:0]     b_base_reg;

    logic [COUNT_W-1:0]  count_sat;
    logic [LANES-1:0]    lane_en;
    logic [OFFSET_W-1:0] word_base;
    quote_mode_t         quote_in;
    quote_mode_t         quote_out;
    logic [LANES-1:0]    hit_mask;
    logic                has_hits;
    logic                b_done;
    logic                a_moves;

    logic [IDX_W-1:0]    pick_idx;
    logic [LANES-1:0]    b_mask_next;
    logic                b_last;

    // Saturate the byte count and open the valid lanes.
    always_comb begin
        count_sat = (a_count_reg > LANES_CNT) ? LANES_CNT : a_count_reg;
        for (int k = 0; k < LANES; k++) begin
            lane_en[k] = (COUNT_W'(k) < count_sat);
        end
    end

    // A stream start drops the running offset and quote mode for this word.
    assign word_base = a_start_reg ? '0 : offset_reg;
    assign quote_in  = a_start_reg ? QM_NONE : quote_reg;

    mscs_lane_scan #(
        .LANES (LANES)
    ) u_lane_scan (
        .lane_bytes (a_bytes_reg),
        .lane_en    (lane_en),
        .quote_in   (quote_in),
        .hit_mask   (hit_mask),
        .quote_out  (quote_out)
    );

    assign has_hits = |hit_mask;

    // Lowest pending hit goes out first.
    always_comb begin
        pick_idx = '0;
        for (int k = LANES - 1; k >= 0; k--) begin
            if (b_mask_reg[k]) begin
                pick_idx = IDX_W'(k);
            end
        end
    end

    assign b_mask_next = b_mask_reg & (b_mask_reg - LANES'(1));
    assign b_last      = (b_mask_next == '0);
    assign b_done      = b_valid_reg && m_ready && b_last;

    // Advance a word when its hits have somewhere to go, or when it has none.
    assign a_moves = a_valid_reg && (!has_hits || !b_valid_reg || b_done);
    assign s_ready = !a_valid_reg || a_moves;

    assign m_valid             = b_valid_reg;
    assign m_word.char_offset  = b_base_reg + OFFSET_W'(pick_idx);
    assign m_word.char_value   = b_bytes_reg[pick_idx*CHAR_W +: CHAR_W];
    assign m_word.last_of_word = b_last;

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            offset_reg  <= '0;
            quote_reg   <= QM_NONE;
        end else begin
            if (s_valid && s_ready) begin
                a_valid_reg <= 1'b1;
            end else if (a_moves) begin
                a_valid_reg <= 1'b0;
            end

            if (a_moves) begin
                offset_reg <= word_base + OFFSET_W'(count_sat);
                quote_reg  <= quote_out;
            end

            if (a_moves && has_hits) begin
                b_valid_reg <= 1'b1;
            end else if (b_done) begin
                b_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: hold while stalled, load on handshake.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            a_bytes_reg <= s_word.text_word[LANES*CHAR_W-1:0];
            a_count_reg <= s_word.byte_count;
            a_start_reg <= s_word.stream_start;
        end

        if (a_moves && has_hits) begin
            b_mask_reg  <= hit_mask;
            b_bytes_reg <= a_bytes_reg;
            b_base_reg  <= word_base;
        end else if (b_valid_reg && m_ready) begin
            b_mask_reg <= b_mask_next;
        end
    end

endmodule
